/* sv/clni_pkg.sv */
// ----------------------------------------------------------------------------
// clni_pkg: shared types and constants of the character LCD nibble interface
// Holds the request codes, the queue descriptor and the init sequence table.
// ----------------------------------------------------------------------------
package clni_pkg;

	localparam logic [1:0] CMD_COMMAND = 2'd0;
	localparam logic [1:0] CMD_DATA    = 2'd1;
	localparam logic [1:0] CMD_CURSOR  = 2'd2;
	localparam logic [1:0] CMD_INIT    = 2'd3;

	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = 1;
	localparam int QueueCntW  = 2;

	localparam int IdxW    = 4;

	localparam logic [15:0] POWER_UP_US     = 16'd40000;
	localparam logic [15:0] FIRST_EXTRA_US  = 16'd4100;
	localparam logic [10:0] SECOND_EXTRA_US = 11'd100;
	localparam logic [10:0] HOME_EXTRA_US   = 11'd1520;

	localparam logic [7:0] GAP_RESET = 8'd36;

	localparam logic [1:0] REG_NIBBLE_GAP = 2'd0;

	typedef enum logic {
		KIND_BYTE,
		KIND_INIT
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       rs;
		logic [7:0] value;
	} desc_t;

	typedef struct packed {
		logic [3:0]  nibble;
		logic [15:0] wait_pre;
		logic [10:0] extra;
		logic        last;
	} init_entry_t;

	function automatic init_entry_t init_entry(input logic [IdxW-1:0] idx);
		init_entry_t e;
		e = '{nibble: 4'h0, wait_pre: 16'd0, extra: 11'd0, last: 1'b0};
		case (idx)
			4'd0:  begin e.nibble = 4'h3; e.wait_pre = POWER_UP_US; end
			4'd1:  begin
				e.nibble   = 4'h3;
				e.wait_pre = FIRST_EXTRA_US;
				e.extra    = SECOND_EXTRA_US;
			end
			4'd2:  e.nibble = 4'h3;
			4'd3:  e.nibble = 4'h2;
			4'd4:  e.nibble = 4'h2;
			4'd5:  e.nibble = 4'h8;
			4'd6:  e.nibble = 4'h0;
			4'd7:  e.nibble = 4'hC;
			4'd8:  e.nibble = 4'h0;
			4'd9:  e.nibble = 4'h6;
			4'd10: e.nibble = 4'h0;
			4'd11: begin
				e.nibble = 4'h2;
				e.extra  = HOME_EXTRA_US;
				e.last   = 1'b1;
			end
			default: e.nibble = 4'h0;
		endcase
		return e;
	endfunction

endpackage

/* sv/clni_front.sv */
// ----------------------------------------------------------------------------
// clni_front: request intake
// Accepts requests and turns each into a descriptor for the queue.
// ----------------------------------------------------------------------------
module clni_front (
	input  logic            item_valid,
	output logic            item_ready,
	input  logic [1:0]      cmd,
	input  logic [7:0]      byte_value,
	input  logic [5:0]      column,
	input  logic            row,
	input  logic            q_full,
	output logic            q_push,
	output clni_pkg::desc_t q_desc
);

	assign item_ready = !q_full;
	assign q_push     = item_valid && !q_full;

	always_comb begin
		q_desc.kind  = clni_pkg::KIND_BYTE;
		q_desc.rs    = 1'b0;
		q_desc.value = byte_value;
		case (cmd)
			clni_pkg::CMD_COMMAND: q_desc.rs = 1'b0;
			clni_pkg::CMD_DATA:    q_desc.rs = 1'b1;
			clni_pkg::CMD_CURSOR:  q_desc.value = {1'b1, row, column};
			clni_pkg::CMD_INIT:    q_desc.kind = clni_pkg::KIND_INIT;
			default:               q_desc.kind = clni_pkg::KIND_BYTE;
		endcase
	end

endmodule

/* sv/clni_queue.sv */
// ----------------------------------------------------------------------------
// clni_queue: descriptor queue
// A short first-in first-out queue between the intake and the sequencer.
// ----------------------------------------------------------------------------
module clni_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  clni_pkg::desc_t push_desc,
	input  logic            pop,
	output clni_pkg::desc_t pop_desc,
	output logic            full,
	output logic            empty
);

	clni_pkg::desc_t                   mem_q [clni_pkg::QueueDepth];
	logic [clni_pkg::QueuePtrW-1:0]    wr_ptr_q;
	logic [clni_pkg::QueuePtrW-1:0]    rd_ptr_q;
	logic [clni_pkg::QueueCntW-1:0]    count_q;

	assign full     = count_q == clni_pkg::QueueCntW'(clni_pkg::QueueDepth);
	assign empty    = count_q == '0;
	assign pop_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/clni_back.sv */
// ----------------------------------------------------------------------------
// clni_back: nibble sequencer
// Expands each descriptor into nibble transfers and holds them in an output
// register until the pin driver takes them.
// ----------------------------------------------------------------------------
module clni_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      gap_us,
	input  logic            q_empty,
	input  clni_pkg::desc_t q_desc,
	output logic            q_pop,
	output logic            result_valid,
	input  logic            result_ready,
	output logic            reg_select,
	output logic [3:0]      nibble,
	output logic [15:0]     wait_before_us,
	output logic [10:0]     wait_after_us,
	output logic            last
);

	logic                      busy_q;
	clni_pkg::desc_t           desc_q;
	logic [clni_pkg::IdxW-1:0] idx_q;
	logic                      out_free;
	logic                      emit;
	clni_pkg::init_entry_t     ent;
	logic                      e_rs;
	logic [3:0]                e_nibble;
	logic [15:0]               e_before;
	logic [10:0]               e_extra;
	logic                      e_last;

	assign out_free = !result_valid || result_ready;
	assign emit     = busy_q && out_free;
	assign q_pop    = !q_empty && (!busy_q || (emit && e_last));
	assign ent      = clni_pkg::init_entry(idx_q);

	always_comb begin
		if (desc_q.kind == clni_pkg::KIND_INIT) begin
			e_rs     = 1'b0;
			e_nibble = ent.nibble;
			e_before = ent.wait_pre;
			e_extra  = ent.extra;
			e_last   = ent.last;
		end else begin
			e_rs     = desc_q.rs;
			e_nibble = idx_q[0] ? desc_q.value[3:0] : desc_q.value[7:4];
			e_before = '0;
			e_extra  = '0;
			e_last   = idx_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			idx_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (out_free) begin
				result_valid <= emit;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				busy_q <= !e_last;
				idx_q  <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q <= q_desc;
		end
		if (emit) begin
			reg_select     <= e_rs;
			nibble         <= e_nibble;
			wait_before_us <= e_before;
			wait_after_us  <= {3'b000, gap_us} + e_extra;
			last           <= e_last;
		end
	end

endmodule

/* sv/char_lcd_nibble_interface.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface: character LCD controller on a 4-bit bus
// Turns command, data, cursor and init requests into timed nibble transfers.
// ----------------------------------------------------------------------------
// Requests enter on item_valid/item_ready with cmd, byte_value, column and
// row. Each result on result_valid/result_ready describes one enable strobe:
// reg_select, nibble, the waits before and after it, and last on the final
// nibble of the request.
// A request is taken into a two-entry descriptor queue; the sequencer loads
// it from there into its descriptor register, and the first nibble then
// passes from that register into the output register.
// The sequencer emits one nibble per cycle while the receiver takes them; a
// byte request gives two nibbles and an init request twelve, and the next
// descriptor is loaded in the cycle of the last nibble of the current one.
// When the receiver stalls, the output register holds its result, the
// sequencer waits, and the queue keeps accepting requests until it is full.
// Reset empties the queue and the output register and sets nibble_gap_us
// to 36. The gap register sits at byte address 0 of the APB port and should
// only be written while no request is in flight.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  byte_value,
	input  logic [5:0]  column,
	input  logic        row,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        reg_select,
	output logic [3:0]  nibble,
	output logic [15:0] wait_before_us,
	output logic [10:0] wait_after_us,
	output logic        last
);

	logic [7:0]      gap_q;
	logic            gap_sel;
	logic            q_full;
	logic            q_empty;
	logic            q_push;
	logic            q_pop;
	clni_pkg::desc_t push_desc;
	clni_pkg::desc_t pop_desc;

	assign pready  = 1'b1;
	assign gap_sel = {1'b0, paddr[2]} == clni_pkg::REG_NIBBLE_GAP;
	assign prdata  = gap_sel ? {24'd0, gap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= clni_pkg::GAP_RESET;
		end else if (psel && penable && pwrite && pready && gap_sel) begin
			gap_q <= pwdata[7:0];
		end
	end

	clni_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cmd        (cmd),
		.byte_value (byte_value),
		.column     (column),
		.row        (row),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_desc     (push_desc)
	);

	clni_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.pop       (q_pop),
		.pop_desc  (pop_desc),
		.full      (q_full),
		.empty     (q_empty)
	);

	clni_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.gap_us         (gap_q),
		.q_empty        (q_empty),
		.q_desc         (pop_desc),
		.q_pop          (q_pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.reg_select     (reg_select),
		.nibble         (nibble),
		.wait_before_us (wait_before_us),
		.wait_after_us  (wait_after_us),
		.last           (last)
	);

endmodule

/* sv/clni_checker.sv */
// ----------------------------------------------------------------------------
// clni_checker: port-level checks for the LCD nibble interface
// Watches the result channel and the timing fields it carries.
// ----------------------------------------------------------------------------
module clni_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic        reg_select,
	input logic [3:0]  nibble,
	input logic [15:0] wait_before_us,
	input logic [10:0] wait_after_us,
	input logic        last
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(nibble)
			&& $stable(reg_select) && $stable(last))
		else $error("Result changed while stalled.");

	a_data_plain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && reg_select |-> wait_before_us == 16'd0
			&& wait_after_us <= 11'd255)
		else $error("Data nibble carries an init wait.");

	a_power_up: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && wait_before_us == 16'd40000 |-> nibble == 4'h3
			&& !reg_select && !last)
		else $error("Power-up wait on a wrong nibble.");

	a_second_init: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && wait_before_us == 16'd4100 |-> nibble == 4'h3
			&& wait_after_us >= 11'd100 && !last)
		else $error("Second init nibble is malformed.");

endmodule

bind char_lcd_nibble_interface clni_checker u_clni_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: randomised check of the character LCD nibble interface
// Command, data, cursor and init requests are offered to the block under
// several gap settings and idling patterns. Every nibble strobe that comes
// back is compared with a strobe list worked out when its request is taken.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WatchdogLimit = 4000;
	localparam logic [2:0] GAP_ADDR = 3'(4 * clni_pkg::REG_NIBBLE_GAP);

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] bv;
		logic [5:0] col;
		logic       r;
	} lcd_req_t;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nib;
		logic [15:0] wait_pre;
		logic [10:0] after;
		logic        fin;
	} strobe_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [1:0]  cmd = clni_pkg::CMD_COMMAND;
	logic [7:0]  byte_value = '0;
	logic [5:0]  column = '0;
	logic        row = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        reg_select;
	logic [3:0]  nibble;
	logic [15:0] wait_before_us;
	logic [10:0] wait_after_us;
	logic        last;

	lcd_req_t requests_waiting[$];
	lcd_req_t next_req;
	strobe_t  strobes_due[$];
	strobe_t  want;
	strobe_t  got;
	logic [7:0] gap_model = clni_pkg::GAP_RESET;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_len = 0;
	int hold_left = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	char_lcd_nibble_interface u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.cmd(cmd),
		.byte_value(byte_value),
		.column(column),
		.row(row),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.reg_select(reg_select),
		.nibble(nibble),
		.wait_before_us(wait_before_us),
		.wait_after_us(wait_after_us),
		.last(last)
	);

	always #10 clk = ~clk;

	function automatic void push_strobe(input logic rs, input logic [3:0] nib,
			input logic [15:0] pre_us, input logic [10:0] extra, input logic fin);
		strobe_t s;
		s.rs = rs;
		s.nib = nib;
		s.wait_pre = pre_us;
		s.after = 11'(gap_model) + extra;
		s.fin = fin;
		strobes_due.push_back(s);
	endfunction

	function automatic void push_byte(input logic rs, input logic [7:0] b,
			input logic [10:0] extra, input logic fin);
		push_strobe(rs, b[7:4], 16'd0, 11'd0, 1'b0);
		push_strobe(rs, b[3:0], 16'd0, extra, fin);
	endfunction

	function automatic void plan_strobes(input logic [1:0] op, input logic [7:0] bv,
			input logic [5:0] col, input logic r);
		logic [7:0] setup_bytes[4];
		setup_bytes = '{8'h28, 8'h0C, 8'h06, 8'h02};
		case (op)
			clni_pkg::CMD_COMMAND: push_byte(1'b0, bv, 11'd0, 1'b1);
			clni_pkg::CMD_DATA: push_byte(1'b1, bv, 11'd0, 1'b1);
			clni_pkg::CMD_CURSOR: push_byte(1'b0, {1'b1, r, col}, 11'd0, 1'b1);
			default: begin
				push_strobe(1'b0, 4'h3, clni_pkg::POWER_UP_US, 11'd0, 1'b0);
				push_strobe(1'b0, 4'h3, clni_pkg::FIRST_EXTRA_US,
					clni_pkg::SECOND_EXTRA_US, 1'b0);
				push_strobe(1'b0, 4'h3, 16'd0, 11'd0, 1'b0);
				push_strobe(1'b0, 4'h2, 16'd0, 11'd0, 1'b0);
				for (int i = 0; i < 4; i++)
					push_byte(1'b0, setup_bytes[i],
						(i == 3) ? clni_pkg::HOME_EXTRA_US : 11'd0, i == 3);
			end
		endcase
	endfunction

	function automatic void add_request(input logic [1:0] op, input logic [7:0] bv,
			input logic [5:0] col, input logic r);
		lcd_req_t q;
		q.op = op;
		q.bv = bv;
		q.col = col;
		q.r = r;
		requests_waiting.push_back(q);
	endfunction

	function automatic void add_random_requests(input int count);
		logic [1:0] op;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(9) == 0) ? clni_pkg::CMD_INIT : 2'($urandom_range(2));
			add_request(op, 8'($urandom), 6'($urandom), 1'($urandom));
		end
	endfunction

	task automatic write_gap(input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= GAP_ADDR;
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		gap_model = value;
	endtask

	task automatic wait_drained();
		while (requests_waiting.size() != 0 || item_valid || strobes_due.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic run_phase(input logic [7:0] gap, input int send_pct, input int stall,
			input int count, input int hold);
		wait_drained();
		write_gap(gap);
		@(negedge clk);
		send_idle_pct = send_pct;
		stall_pct = stall;
		if (hold != 0) begin
			hold_len = hold;
			hold_asked++;
		end
		add_random_requests(count);
	endtask

	// Request driver: takes the next pending request once the current one is gone.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				plan_strobes(cmd, byte_value, column, row);
			if (!item_valid || item_ready) begin
				if (requests_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = requests_waiting.pop_front();
					item_valid <= 1'b1;
					cmd <= next_req.op;
					byte_value <= next_req.bv;
					column <= next_req.col;
					row <= next_req.r;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Strobe monitor with its own back-pressure.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				got = '{reg_select, nibble, wait_before_us, wait_after_us, last};
				if (strobes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected strobe: rs=%0d nib=%h pre=%0d post=%0d last=%0d",
							got.rs, got.nib, got.wait_pre, got.after, got.fin);
				end else begin
					want = strobes_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("strobe mismatch: expected %0d %h %0d %0d %0d, got %0d %h %0d %0d %0d",
								want.rs, want.nib, want.wait_pre, want.after, want.fin,
								got.rs, got.nib, got.wait_pre, got.after, got.fin);
					end
				end
			end
			if (hold_seen != hold_asked) begin
				hold_seen <= hold_asked;
				hold_left <= hold_len;
				result_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_request(clni_pkg::CMD_COMMAND, 8'h00, 6'h3F, 1'b1);
		add_request(clni_pkg::CMD_COMMAND, 8'hFF, 6'h00, 1'b0);
		add_request(clni_pkg::CMD_DATA, 8'h00, 6'h2A, 1'b1);
		add_request(clni_pkg::CMD_DATA, 8'hFF, 6'h15, 1'b0);
		add_request(clni_pkg::CMD_DATA, 8'hA5, 6'h3F, 1'b1);
		add_request(clni_pkg::CMD_COMMAND, 8'h5A, 6'h00, 1'b0);
		add_request(clni_pkg::CMD_CURSOR, 8'hFF, 6'h00, 1'b0);
		add_request(clni_pkg::CMD_CURSOR, 8'h00, 6'h3F, 1'b1);
		add_request(clni_pkg::CMD_CURSOR, 8'hC3, 6'h00, 1'b1);
		add_request(clni_pkg::CMD_CURSOR, 8'h3C, 6'h3F, 1'b0);
		add_request(clni_pkg::CMD_CURSOR, 8'h00, 6'h15, 1'b1);
		add_request(clni_pkg::CMD_INIT, 8'h00, 6'h00, 1'b0);
		add_request(clni_pkg::CMD_INIT, 8'hFF, 6'h3F, 1'b1);
		add_request(clni_pkg::CMD_DATA, 8'h3C, 6'h00, 1'b0);
		add_request(clni_pkg::CMD_COMMAND, 8'h01, 6'h2A, 1'b0);

		run_phase(8'd0, 0, 0, 70, 0);
		run_phase(8'd255, 85, 0, 60, 0);
		run_phase(8'($urandom), 0, 85, 60, 0);
		run_phase(8'd1, 13, 13, 70, 400);
		run_phase(8'($urandom), 0, 0, 60, 0);

		while (requests_waiting.size() != 0 || item_valid || strobes_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* sim.f */
sv/clni_pkg.sv
sv/clni_front.sv
sv/clni_queue.sv
sv/clni_back.sv
sv/char_lcd_nibble_interface.sv
sv/clni_checker.sv
tb/testbench.sv
